[hw/rtl/isotp_pkg.sv]
// Shared types, codes and constants of the ISO-TP response reassembly block.
`default_nettype none
package isotp_pkg;

    localparam int ISOTP_QUEUE_DEPTH = 2;

    localparam logic [1:0] CFG_SERVICE   = 2'd0;
    localparam logic [1:0] CFG_PID       = 2'd1;
    localparam logic [1:0] CFG_PID_OFF   = 2'd2;

    localparam logic       OP_START      = 1'b0;

    localparam logic [3:0] FT_SINGLE     = 4'h0;
    localparam logic [3:0] FT_FIRST      = 4'h1;
    localparam logic [3:0] FT_CONSEC     = 4'h2;

    localparam logic [8:0] SERVICE_ECHO  = 9'h040;
    localparam logic [3:0] SF_HDR_BYTES  = 4'd2;
    localparam logic [2:0] SF_MAX_BYTES  = 3'd5;
    localparam logic [2:0] FF_MAX_BYTES  = 3'd4;
    localparam logic [2:0] CF_MAX_BYTES  = 3'd7;
    localparam logic [11:0] MF_HDR_BYTES = 12'd2;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_FLOW = 2'd1,
        K_DONE = 2'd2,
        K_FAIL = 2'd3
    } kind_t;

    typedef struct packed {
        logic [6:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic [11:0]     base;
        kind_t           term;
    } job_t;

endpackage
`default_nettype wire

[hw/rtl/isotp_front.sv]
// Front end: config registers, frame classification and reassembly state.
`default_nettype none
module isotp_front
    import isotp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        q_full,
    output logic             push,
    output job_t             push_job
);

    logic [7:0]  svc_reg;
    logic [7:0]  pid_reg;
    logic        pid_off_reg;
    phase_t      phase_reg, phase_next;
    logic [11:0] total_reg, total_next;
    logic [11:0] emitted_reg, emitted_next;

    logic [7:0][7:0] b;
    logic [3:0]  ftype;
    logic [3:0]  low;
    logic        accept;
    logic [11:0] ff_total;
    logic [11:0] bnd_src;
    logic [11:0] bnd;
    logic [11:0] rem;
    logic [2:0]  cap;
    logic        more;
    logic [2:0]  take;
    logic [3:0]  sf_len;
    logic [2:0]  sf_take;
    logic        svc_ok;
    logic        pid_ok;

    logic        job_valid;
    phase_t      phase_cls;
    logic [11:0] total_cls;
    logic [11:0] emitted_cls;

    assign b        = s_tdata;
    assign ftype    = b[0][7:4];
    assign low      = b[0][3:0];
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign ff_total = {low, b[1]};
    assign bnd_src  = (phase_reg == PH_WAIT) ? ff_total : total_reg;
    assign bnd      = (bnd_src >= MF_HDR_BYTES) ? bnd_src - MF_HDR_BYTES : 12'd0;
    assign rem      = (emitted_reg < bnd) ? bnd - emitted_reg : 12'd0;
    assign cap      = (phase_reg == PH_WAIT) ? FF_MAX_BYTES : CF_MAX_BYTES;
    assign more     = rem > {9'd0, cap};
    assign take     = more ? cap : rem[2:0];

    assign sf_len   = (low >= SF_HDR_BYTES) ? low - SF_HDR_BYTES : 4'd0;
    assign sf_take  = (sf_len > {1'b0, SF_MAX_BYTES}) ? SF_MAX_BYTES : sf_len[2:0];
    assign svc_ok   = {1'b0, b[1]} == ({1'b0, svc_reg} + SERVICE_ECHO);
    assign pid_ok   = pid_off_reg || (b[2] == pid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svc_reg     <= 8'd1;
            pid_reg     <= 8'd0;
            pid_off_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SERVICE: svc_reg     <= cfg_data;
                CFG_PID:     pid_reg     <= cfg_data;
                CFG_PID_OFF: pid_off_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // frame classification and job build
    always_comb
    begin
        job_valid       = 1'b0;
        push_job.bytes  = '0;
        push_job.nbytes = 3'd0;
        push_job.base   = emitted_reg;
        push_job.term   = K_DONE;
        phase_cls       = phase_reg;
        total_cls       = total_reg;
        emitted_cls     = emitted_reg;
        case (phase_reg)
            PH_WAIT:
            begin
                job_valid = 1'b1;
                phase_cls = PH_DONE;
                case (ftype)
                    FT_SINGLE:
                    begin
                        if (svc_ok && pid_ok)
                        begin
                            push_job.bytes[0] = b[3];
                            push_job.bytes[1] = b[4];
                            push_job.bytes[2] = b[5];
                            push_job.bytes[3] = b[6];
                            push_job.bytes[4] = b[7];
                            push_job.nbytes   = sf_take;
                            emitted_cls       = emitted_reg + {9'd0, sf_take};
                        end
                        else
                        begin
                            push_job.term = K_FAIL;
                        end
                    end
                    FT_FIRST:
                    begin
                        push_job.bytes[0] = b[4];
                        push_job.bytes[1] = b[5];
                        push_job.bytes[2] = b[6];
                        push_job.bytes[3] = b[7];
                        push_job.nbytes   = take;
                        push_job.term     = more ? K_FLOW : K_DONE;
                        total_cls         = ff_total;
                        emitted_cls       = emitted_reg + {9'd0, take};
                        phase_cls         = more ? PH_COLLECT : PH_DONE;
                    end
                    default:
                    begin
                        push_job.term = K_FAIL;
                    end
                endcase
            end
            PH_COLLECT:
            begin
                job_valid = 1'b1;
                if (ftype == FT_CONSEC)
                begin
                    push_job.bytes  = b[7:1];
                    push_job.nbytes = take;
                    push_job.term   = more ? K_FLOW : K_DONE;
                    emitted_cls     = emitted_reg + {9'd0, take};
                    phase_cls       = more ? PH_COLLECT : PH_DONE;
                end
                else
                begin
                    push_job.term = K_FLOW;
                end
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    assign push = accept && (s_tuser != OP_START) && job_valid;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        total_next   = total_reg;
        emitted_next = emitted_reg;
        if (accept)
        begin
            if (s_tuser == OP_START)
            begin
                phase_next   = PH_WAIT;
                total_next   = 12'd0;
                emitted_next = 12'd0;
            end
            else
            begin
                phase_next   = phase_cls;
                total_next   = total_cls;
                emitted_next = emitted_cls;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            total_reg   <= 12'd0;
            emitted_reg <= 12'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            total_reg   <= total_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/isotp_queue.sv]
// Small job queue between the front end and the result sequencer.
`default_nettype none
module isotp_queue
    import isotp_pkg::*;
#(
    parameter int DEPTH = ISOTP_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      head,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = cnt_reg == CNT_W'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/isotp_back.sv]
// Result sequencer: expands one job into payload and status transactions.
`default_nettype none
module isotp_back
    import isotp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire job_t        head,
    input  wire logic        empty,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [11:0] count_reg, count_next;
    logic        last_reg, last_next;
    logic [2:0]  idx_reg, idx_next;
    logic        load;
    logic        is_term;
    logic [11:0] count_calc;

    assign load       = !valid_reg || m_tready;
    assign is_term    = idx_reg == head.nbytes;
    assign count_calc = head.base + {9'd0, idx_reg} + {11'd0, !is_term};
    assign pop        = load && !empty && is_term;

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        data_next  = data_reg;
        count_next = count_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (is_term)
                begin
                    kind_next  = head.term;
                    data_next  = 8'd0;
                    count_next = (head.term == K_FAIL) ? 12'd0 : count_calc;
                    last_next  = 1'b1;
                    idx_next   = 3'd0;
                end
                else
                begin
                    kind_next  = K_DATA;
                    data_next  = head.bytes[idx_reg];
                    count_next = count_calc;
                    last_next  = 1'b0;
                    idx_next   = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        data_reg  <= data_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, count_reg, data_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

[hw/rtl/isotp_response_reassembly.sv]
// Top level: ISO-TP diagnostic response reassembly, front end, job queue, sequencer.
// The first result of a frame passes through the job queue and the sequencer output register.
// Throughput: one result per cycle unless m_tready stalls; a frame yields up to 8 results,
// so the sequencer output register sets the sustained rate at which frames drain.
// Frames are accepted every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset: asynchronous, clears state to waiting, config to service 1, PID 0, check on.
`default_nettype none
module isotp_response_reassembly
    import isotp_pkg::*;
#(
    parameter int QUEUE_DEPTH = ISOTP_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // byte0, byte1, ..., byte7
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // data_byte[7:0], byte_count[19:8], zero pad
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast
);

    logic q_push;
    job_t q_push_job;
    logic q_full;
    logic q_pop;
    job_t q_head;
    logic q_empty;

    isotp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .push_job (q_push_job)
    );

    isotp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_job(q_push_job),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty)
    );

    isotp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .empty   (q_empty),
        .pop     (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty at once");

    a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == K_DATA) |-> !m_tlast)
        else $error("payload transaction marked last");

    a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == K_FAIL) |-> (m_tlast && m_tdata[19:0] == 20'd0))
        else $error("failed result not last or nonzero");

endmodule
`default_nettype wire

[tb/isotp_response_reassembly_checker.sv]
// Checker for the ISO-TP response reassembly: predicts results of each accepted frame and compares.
module isotp_response_reassembly_checker
    import isotp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,   // byte0, byte1, ..., byte7
    input  wire logic        s_tuser,   // op
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // data_byte[7:0], byte_count[19:8], zero pad
    input  wire logic [1:0]  m_tuser,   // kind
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               outstanding
);

    typedef struct {
        kind_t       kind;
        logic [7:0]  data;
        logic [11:0] count;
        logic        last;
    } result_t;

    result_t     reassembly_q [$];
    result_t     frame_res [8];
    result_t     head;
    int          frame_n;
    int          errors;
    logic [7:0]  fb [8];

    logic [7:0]  service;
    logic [7:0]  pid;
    logic        pid_skip;
    phase_t      phase;
    logic [11:0] total_len;
    logic [11:0] emitted;

    function automatic logic [11:0] payload_bound(input logic [11:0] total);
        return (total >= MF_HDR_BYTES) ? total - MF_HDR_BYTES : 12'd0;
    endfunction

    task automatic add(input kind_t k, input logic [7:0] d, input logic [11:0] c);
        frame_res[frame_n] = '{k, d, c, 1'b0};
        frame_n++;
    endtask

    task automatic append_payload(input int first, input int cnt);
        for (int i = 0; i < cnt; i++)
        begin
            if (emitted < payload_bound(total_len))
            begin
                emitted = emitted + 12'd1;
                add(K_DATA, fb[first + i], emitted);
            end
        end
        if (emitted < payload_bound(total_len))
        begin
            add(K_FLOW, 8'h00, emitted);
            phase = PH_COLLECT;
        end
        else
        begin
            add(K_DONE, 8'h00, emitted);
            phase = PH_DONE;
        end
    endtask

    task automatic reassemble_frame(input logic op, input logic [63:0] frame);
        logic [3:0] ftype;
        logic [3:0] low;
        logic [3:0] sf_len;
        logic       match;
        for (int i = 0; i < 8; i++)
            fb[i] = frame[8*i +: 8];
        ftype   = fb[0][7:4];
        low     = fb[0][3:0];
        frame_n = 0;
        if (op == OP_START)
        begin
            phase     = PH_WAIT;
            total_len = 12'd0;
            emitted   = 12'd0;
        end
        else if (phase == PH_WAIT)
        begin
            if (ftype == FT_SINGLE)
            begin
                match = ({1'b0, fb[1]} == {1'b0, service} + SERVICE_ECHO) &&
                        (pid_skip || fb[2] == pid);
                if (match)
                begin
                    sf_len = (low >= SF_HDR_BYTES) ? low - SF_HDR_BYTES : 4'd0;
                    if (sf_len > {1'b0, SF_MAX_BYTES})
                        sf_len = {1'b0, SF_MAX_BYTES};
                    for (int i = 0; i < int'(sf_len); i++)
                    begin
                        emitted = emitted + 12'd1;
                        add(K_DATA, fb[3 + i], emitted);
                    end
                    add(K_DONE, 8'h00, emitted);
                end
                else
                    add(K_FAIL, 8'h00, 12'd0);
                phase = PH_DONE;
            end
            else if (ftype == FT_FIRST)
            begin
                total_len = {low, fb[1]};
                append_payload(4, int'(FF_MAX_BYTES));
            end
            else
            begin
                add(K_FAIL, 8'h00, 12'd0);
                phase = PH_DONE;
            end
        end
        else if (phase == PH_COLLECT)
        begin
            if (ftype == FT_CONSEC)
                append_payload(1, int'(CF_MAX_BYTES));
            else
                add(K_FLOW, 8'h00, emitted);
        end
        for (int i = 0; i < frame_n; i++)
        begin
            if (i == frame_n - 1)
                frame_res[i].last = 1'b1;
            reassembly_q.push_back(frame_res[i]);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            service   = 8'h01;
            pid       = 8'h00;
            pid_skip  = 1'b0;
            phase     = PH_WAIT;
            total_len = 12'd0;
            emitted   = 12'd0;
            errors    = 0;
            reassembly_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SERVICE: service  = cfg_data;
                    CFG_PID:     pid      = cfg_data;
                    CFG_PID_OFF: pid_skip = cfg_data[0];
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready)
                reassemble_frame(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (reassembly_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result kind %0d data %02h count %0d last %0b",
                                 $realtime, m_tuser, m_tdata[7:0], m_tdata[19:8], m_tlast);
                end
                else
                begin
                    head = reassembly_q.pop_front();
                    if (m_tuser != head.kind || m_tdata[7:0] != head.data ||
                        m_tdata[19:8] != head.count || m_tlast != head.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: exp %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
                                     $realtime, head.kind, head.data, head.count, head.last,
                                     m_tuser, m_tdata[7:0], m_tdata[19:8], m_tlast);
                    end
                end
            end
        end
        outstanding <= reassembly_q.size();
        mismatches  <= errors;
    end

endmodule

[tb/isotp_response_reassembly_tb.sv]
// Testbench top for the ISO-TP response reassembly: clock, reset, frame stimulus and verdict.
module isotp_response_reassembly_tb;
    import isotp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // byte0, byte1, ..., byte7
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // data_byte[7:0], byte_count[19:8], zero pad
    logic [1:0]  m_tuser;   // kind
    logic        m_tlast;
    int          mismatches;
    int          outstanding;

    logic        tx_gaps;
    logic        rx_gaps;
    logic        hold_off;
    logic [7:0]  svc;
    logic [7:0]  pid;
    int          sent;

    isotp_response_reassembly dut (.*);

    isotp_response_reassembly_checker u_checker (.*);

    always #6 clk = ~clk;

    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(12 * 200000);
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        logic held;
        held = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            m_tready <= !rx_gaps || ($urandom_range(99) >= 25);
        end
    end

    function automatic logic [63:0] can_frame(input logic [7:0] pci, input logic [7:0] b1,
                                              input logic [7:0] b2);
        logic [63:0] f;
        f        = {$urandom(), $urandom()};
        f[23:0]  = {b2, b1, pci};
        return f;
    endfunction

    task automatic send(input logic op, input logic [63:0] frame);
        while (tx_gaps && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= frame;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] service, input logic [7:0] id,
                                input logic skip);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SERVICE;
        cfg_data  <= service;
        @(posedge clk);
        cfg_index <= CFG_PID;
        cfg_data  <= id;
        @(posedge clk);
        cfg_index <= CFG_PID_OFF;
        cfg_data  <= {7'd0, skip};
        @(posedge clk);
        cfg_we    <= 1'b0;
        svc = service;
        pid = id;
    endtask

    task automatic random_traffic(input int quota);
        int          first;
        int          r;
        int          ncf;
        logic [11:0] total;
        logic [3:0]  t;
        first = sent;
        while (sent - first < quota)
        begin
            send(OP_START, {$urandom(), $urandom()});
            r = $urandom_range(99);
            if (r < 35)
            begin
                send(1'b1, can_frame({FT_SINGLE, 4'($urandom_range(15))},
                                     ($urandom_range(9) == 0) ? 8'($urandom()) : 8'(svc + 8'h40),
                                     ($urandom_range(9) == 0) ? 8'($urandom()) : pid));
            end
            else if (r < 85)
            begin
                total = ($urandom_range(9) == 0) ? 12'($urandom()) : 12'($urandom_range(40));
                send(1'b1, can_frame({FT_FIRST, total[11:8]}, total[7:0], 8'($urandom())));
                ncf = (total > 12'd6) ? int'(total) / 7 : 0;
                if (ncf > 8)
                    ncf = 8;
                for (int i = 0; i < ncf; i++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        t = 4'($urandom());
                        if (t == FT_CONSEC)
                            t = FT_SINGLE;
                        send(1'b1, can_frame({t, 4'($urandom())}, 8'($urandom()),
                                             8'($urandom())));
                    end
                    send(1'b1, can_frame({FT_CONSEC, 4'(i + 1)}, 8'($urandom()),
                                         8'($urandom())));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send(1'b1, {$urandom(), $urandom()});
            end
        end
    endtask

    initial
    begin
        cfg_we    <= 1'b0;
        cfg_index <= CFG_SERVICE;
        cfg_data  <= 8'h00;
        s_tvalid  <= 1'b0;
        s_tdata   <= 64'd0;
        s_tuser   <= OP_START;
        tx_gaps    = 1'b1;
        rx_gaps    = 1'b1;
        hold_off  <= 1'b0;
        svc        = 8'h01;
        pid        = 8'h00;
        sent       = 0;
        wait (rst_n);
        @(posedge clk);

        // reset config: service 1, pid 0, pid check on
        send(1'b1, {40'hFF_FFFF_FFFF, 8'h00, 8'h41, 8'h07});       // single, len 5
        send(1'b1, can_frame(8'h07, 8'h41, 8'h00));                 // ignored when finished
        send(OP_START, 64'd0);
        send(1'b1, {40'h00_0000_0000, 8'h00, 8'h41, 8'h00});       // single, no payload
        send(OP_START, 64'hFFFF_FFFF_FFFF_FFFF);
        send(1'b1, can_frame(8'h0F, 8'h41, 8'h00));                 // length above 5
        send(OP_START, 64'd0);
        send(1'b1, can_frame(8'h03, 8'h42, 8'h00));                 // service mismatch
        send(OP_START, 64'd0);
        send(1'b1, can_frame(8'h04, 8'h41, 8'h01));                 // pid mismatch
        send(OP_START, 64'd0);
        send(1'b1, can_frame(8'h30, 8'h41, 8'h00));                 // unknown type while waiting
        send(OP_START, 64'd0);
        send(1'b1, can_frame(8'h10, 8'h00, 8'h00));                 // first frame, total 0
        send(OP_START, 64'd0);
        send(1'b1, can_frame(8'h10, 8'h0E, 8'h00));                 // total 14
        send(1'b1, can_frame(8'h05, 8'h41, 8'h00));                 // stray while collecting
        send(1'b1, can_frame(8'h21, 8'h00, 8'h00));
        send(1'b1, can_frame(8'h22, 8'hFF, 8'hFF));                 // clipped at bound
        send(OP_START, 64'd0);
        send(1'b1, can_frame(8'h1F, 8'hFF, 8'h00));                 // total 4095
        send(1'b1, can_frame(8'h2F, 8'h00, 8'h00));
        send(OP_START, 64'd0);                                      // restart mid-response
        quiesce();

        program_regs(8'hBF, 8'hFF, 1'b1);
        send(1'b1, can_frame(8'h05, 8'hFF, 8'h12));                 // pid ignored
        send(OP_START, 64'd0);
        quiesce();

        program_regs(8'hC0, 8'h00, 1'b0);
        send(1'b1, can_frame(8'h07, 8'h00, 8'h00));                 // echo overflows 8 bits
        quiesce();

        program_regs(8'h01, 8'h00, 1'b0);
        hold_off <= 1'b1;
        random_traffic(18);
        quiesce();

        program_regs(8'hFF, 8'h80, 1'b1);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_traffic(18);
        quiesce();

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        program_regs(8'h00, 8'hFF, 1'b0);
        random_traffic(18);
        quiesce();

        program_regs(8'($urandom()), 8'($urandom()), 1'($urandom()));
        random_traffic(18);
        quiesce();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/isotp_pkg.sv
hw/rtl/isotp_front.sv
hw/rtl/isotp_queue.sv
hw/rtl/isotp_back.sv
hw/rtl/isotp_response_reassembly.sv
tb/isotp_response_reassembly_checker.sv
tb/isotp_response_reassembly_tb.sv
